### rtl/breath_cycle_phase_timer_assert.svh
// Assertion helpers for the breath timer, clocked on aclk and held off in reset.
`ifndef BREATH_CYCLE_PHASE_TIMER_ASSERT_SVH
`define BREATH_CYCLE_PHASE_TIMER_ASSERT_SVH

// Same-cycle implication.
`define BCPT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("breath timer check failed");

// Next-cycle implication.
`define BCPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("breath timer check failed");

`endif

### rtl/bcpt_pkg.sv
package bcpt_pkg;

    localparam int TIME_W = 13;
    localparam int DVD_W  = 16;
    localparam int PROD_W = 9;

    // Phase codes as reported on the result channel
    localparam logic [2:0] PH_HOME      = 3'd0;
    localparam logic [2:0] PH_INIT_INSP = 3'd1;
    localparam logic [2:0] PH_INSP      = 3'd2;
    localparam logic [2:0] PH_INIT_EXP  = 3'd3;
    localparam logic [2:0] PH_EXP       = 3'd4;

    // Request opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    // Configuration register indexes
    localparam logic REG_BREATH_RATE = 1'b0;
    localparam logic REG_IE_RATIO    = 1'b1;

    localparam logic [TIME_W-1:0] MAX13     = 13'd8191;
    localparam logic [TIME_W-1:0] LIMIT_MAX = 13'd8190;
    localparam logic [DVD_W-1:0]  CYCLE_MS  = 16'd60000;

    localparam logic [5:0] RATE_RESET = 6'd15;
    localparam logic [2:0] IE_RESET   = 3'd2;

    typedef struct packed {
        logic [1:0] op;
        logic       sensor_error;
    } in_t;

    typedef struct packed {
        logic [2:0]        phase;
        logic              running;
        logic [TIME_W-1:0] insp_time_ms;
        logic [TIME_W-1:0] exp_time_ms;
        logic [TIME_W-1:0] phase_ticks;
    } out_t;

    // Sequencer program steps
    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_DIV_RATE = 4'd1,
        ST_WAIT_R   = 4'd2,
        ST_INSP     = 4'd3,
        ST_EXP      = 4'd4,
        ST_SCALE    = 4'd5,
        ST_LIMIT    = 4'd6,
        ST_COMMIT   = 4'd7,
        ST_DONE     = 4'd8
    } step_t;

    // Jump conditions
    typedef enum logic [2:0] {
        J_NONE     = 3'd0,
        J_ALWAYS   = 3'd1,
        J_NO_REQ   = 3'd2,
        J_BUSY     = 3'd3,
        J_NO_LIMIT = 3'd4,
        J_OUT_FULL = 3'd5
    } jcond_t;

    typedef struct packed {
        logic   accept;
        logic   div_start;
        logic   ld_scale;
        logic   ld_insp;
        logic   ld_exp;
        logic   ld_limit;
        logic   commit;
        jcond_t cond;
        step_t  target;
    } ucode_t;

    // Control store: one word per step
    function automatic ucode_t ucode_rom(step_t s);
        ucode_t w;
        w        = '0;
        w.cond   = J_NONE;
        w.target = ST_IDLE;
        unique case (s)
            ST_IDLE: begin
                w.accept = 1'b1;
                w.cond   = J_NO_REQ;
                w.target = ST_IDLE;
            end
            ST_DIV_RATE: begin
                w.div_start = 1'b1;
            end
            ST_WAIT_R: begin
                w.cond   = J_BUSY;
                w.target = ST_WAIT_R;
            end
            ST_INSP: begin
                w.ld_insp = 1'b1;
            end
            ST_EXP: begin
                w.ld_exp = 1'b1;
                w.cond   = J_NO_LIMIT;
                w.target = ST_COMMIT;
            end
            ST_SCALE: begin
                w.ld_scale = 1'b1;
            end
            ST_LIMIT: begin
                w.ld_limit = 1'b1;
            end
            ST_COMMIT: begin
                w.commit = 1'b1;
                w.cond   = J_OUT_FULL;
                w.target = ST_COMMIT;
            end
            ST_DONE: begin
                w.cond   = J_ALWAYS;
                w.target = ST_IDLE;
            end
            default: begin
                w.cond   = J_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

### rtl/bcpt_div.sv
module bcpt_div #(
    parameter int DVD_W = 16,
    parameter int DVS_W = 9
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;

    logic [DVS_W:0] shifted;
    logic [DVS_W:0] diff;
    logic           fits;

    // One restoring step: shift in the next dividend bit, try to subtract
    always_comb begin
        shifted = {rem_reg, quo_reg[DVD_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        fits    = (shifted >= {1'b0, dvs_reg});
    end

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DVD_W-2:0], fits};
            rem_next = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

### rtl/breath_cycle_phase_timer.sv
// Breath phase timer. Each request (tick, start or stop) yields one result with the
// phase, the running flag, the inspiration and expiration times derived from the
// breath-rate and I:E registers, and the tick count of the current timed phase.
// A request uses the divider and, for a tick in an init phase, the scale and limit
// steps too; a stall on the result channel holds it in the commit step. The 16-step
// radix-2 divider does the cycle-time division (the ms-to-ticks step is a reciprocal
// multiplication by the tick period), run by a nine-step microprogram. A new
// request is taken while the previous result still waits in the output register.
// Write configuration only while idle.
`include "breath_cycle_phase_timer_assert.svh"

module breath_cycle_phase_timer #(
    parameter int TICK_MS = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bcpt_pkg::in_t     s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output bcpt_pkg::out_t    m_data,
    input  logic              cfg_we,
    input  logic              cfg_addr,
    input  logic [5:0]        cfg_wdata
);

    localparam int TW      = bcpt_pkg::TIME_W;
    localparam int DW      = bcpt_pkg::DVD_W;
    localparam int DVS_W   = bcpt_pkg::PROD_W;
    // Reciprocal of the tick period, exact floor division for any 13-bit time
    localparam int TICK_LOG = $clog2(TICK_MS);
    localparam int SHIFT    = TW + TICK_LOG;
    localparam int RECIP    = (1 << SHIFT) / TICK_MS + 1;
    localparam int RECIP_W  = TW + 2;
    localparam int SCALE_W  = TW + RECIP_W;

    bcpt_pkg::step_t  step_reg, step_next;
    bcpt_pkg::ucode_t uc;

    logic [5:0]    rate_reg;
    logic [2:0]    ie_reg;
    bcpt_pkg::in_t req_reg;

    logic [TW-1:0] insp_reg, exp_reg, limit_reg, tick_reg;
    logic [2:0]    phase_reg;
    logic          run_reg;

    logic           m_valid_reg;
    bcpt_pkg::out_t m_data_reg;

    logic [3:0]                  ie_plus;
    logic [bcpt_pkg::PROD_W-1:0] prod;
    logic [DW-1:0]               exp_prod;
    logic                        div_busy;
    logic [DW-1:0]               quo;

    logic [TW-1:0]      scale_src;
    logic [SCALE_W-1:0] scale_reg;
    logic [SCALE_W-1:0] ticks_q;

    logic jump, m_stall, need_limit, accept_fire, commit_fire;

    logic [2:0]    phase_nx;
    logic [TW-1:0] tick_nx;
    logic          run_nx;

    // Decode the current step
    assign uc = bcpt_pkg::ucode_rom(step_reg);

    assign s_ready     = uc.accept;
    assign m_stall     = m_valid_reg && !m_ready;
    assign need_limit  = (req_reg.op == bcpt_pkg::OP_TICK) &&
                         ((phase_reg == bcpt_pkg::PH_INIT_EXP) ||
                          (phase_reg == bcpt_pkg::PH_INIT_INSP));
    assign accept_fire = uc.accept && s_valid;
    assign commit_fire = uc.commit && !m_stall;

    // Evaluate the jump condition and advance the step counter
    always_comb begin
        unique case (uc.cond)
            bcpt_pkg::J_NONE:     jump = 1'b0;
            bcpt_pkg::J_ALWAYS:   jump = 1'b1;
            bcpt_pkg::J_NO_REQ:   jump = !s_valid;
            bcpt_pkg::J_BUSY:     jump = div_busy;
            bcpt_pkg::J_NO_LIMIT: jump = !need_limit;
            bcpt_pkg::J_OUT_FULL: jump = m_stall;
            default:              jump = 1'b1;
        endcase
        step_next = jump ? uc.target : bcpt_pkg::step_t'(step_reg + 4'd1);
    end

    // Datapath: cycle divisor, exp product, ms-to-ticks operand and quotient
    always_comb begin
        ie_plus   = {1'b0, ie_reg} + 4'd1;
        prod      = bcpt_pkg::PROD_W'(rate_reg) * bcpt_pkg::PROD_W'(ie_plus);
        exp_prod  = DW'(insp_reg) * DW'(ie_reg);
        scale_src = (phase_reg == bcpt_pkg::PH_INIT_EXP) ? exp_reg : insp_reg;
        ticks_q   = scale_reg >> SHIFT;
    end

    bcpt_div #(
        .DVD_W (DW),
        .DVS_W (DVS_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (uc.div_start),
        .dividend (bcpt_pkg::CYCLE_MS),
        .divisor  (prod),
        .busy     (div_busy),
        .quotient (quo)
    );

    // Phase machine and run flag update for the held request
    always_comb begin
        phase_nx = phase_reg;
        tick_nx  = tick_reg;
        run_nx   = run_reg;
        unique case (req_reg.op)
            bcpt_pkg::OP_TICK: begin
                unique case (phase_reg)
                    bcpt_pkg::PH_HOME: begin
                        if (req_reg.sensor_error) begin
                            run_nx = 1'b0;
                        end
                        tick_nx  = '0;
                        phase_nx = bcpt_pkg::PH_INIT_EXP;
                    end
                    bcpt_pkg::PH_INIT_EXP: begin
                        tick_nx  = '0;
                        phase_nx = bcpt_pkg::PH_EXP;
                    end
                    bcpt_pkg::PH_INIT_INSP: begin
                        tick_nx  = '0;
                        phase_nx = bcpt_pkg::PH_INSP;
                    end
                    bcpt_pkg::PH_EXP, bcpt_pkg::PH_INSP: begin
                        if (tick_reg > limit_reg) begin
                            tick_nx  = '0;
                            phase_nx = (phase_reg == bcpt_pkg::PH_EXP) ?
                                       bcpt_pkg::PH_INIT_INSP : bcpt_pkg::PH_INIT_EXP;
                        end else begin
                            tick_nx = tick_reg + TW'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            bcpt_pkg::OP_START: run_nx = 1'b1;
            bcpt_pkg::OP_STOP:  run_nx = 1'b0;
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= bcpt_pkg::ST_IDLE;
            rate_reg    <= bcpt_pkg::RATE_RESET;
            ie_reg      <= bcpt_pkg::IE_RESET;
            phase_reg   <= bcpt_pkg::PH_HOME;
            tick_reg    <= '0;
            limit_reg   <= '0;
            run_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            if (cfg_we && (cfg_addr == bcpt_pkg::REG_BREATH_RATE)) begin
                rate_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_addr == bcpt_pkg::REG_IE_RATIO)) begin
                ie_reg <= cfg_wdata[2:0];
            end
            if (uc.ld_limit) begin
                limit_reg <= (ticks_q > SCALE_W'(bcpt_pkg::LIMIT_MAX)) ?
                             bcpt_pkg::LIMIT_MAX : ticks_q[TW-1:0];
            end
            if (commit_fire) begin
                phase_reg <= phase_nx;
                tick_reg  <= tick_nx;
                run_reg   <= run_nx;
            end
            if (commit_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and derived times
    always_ff @(posedge aclk) begin
        if (accept_fire) begin
            req_reg <= s_data;
        end
        if (uc.ld_insp) begin
            insp_reg <= (prod == '0) ? bcpt_pkg::MAX13 :
                        (quo > DW'(bcpt_pkg::MAX13)) ? bcpt_pkg::MAX13 : quo[TW-1:0];
        end
        if (uc.ld_exp) begin
            exp_reg <= (exp_prod > DW'(bcpt_pkg::MAX13)) ?
                       bcpt_pkg::MAX13 : exp_prod[TW-1:0];
        end
        if (uc.ld_scale) begin
            scale_reg <= SCALE_W'(scale_src) * SCALE_W'(RECIP);
        end
        if (commit_fire) begin
            m_data_reg.phase        <= phase_nx;
            m_data_reg.running      <= run_nx;
            m_data_reg.insp_time_ms <= insp_reg;
            m_data_reg.exp_time_ms  <= exp_reg;
            m_data_reg.phase_ticks  <= tick_nx;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A committed result always lands in the output register
    `BCPT_ASSERT_NEXT(a_commit_fills, commit_fire, m_valid_reg)
    // The divider is never restarted mid-division
    `BCPT_ASSERT_IMPL(a_div_free, uc.div_start, !div_busy)
    // Idle sequencer means an idle divider
    `BCPT_ASSERT_IMPL(a_idle_div, s_ready, !div_busy)
    // A timed phase never counts past its limit plus one
    `BCPT_ASSERT_IMPL(a_tick_bound,
        (phase_reg == bcpt_pkg::PH_EXP) || (phase_reg == bcpt_pkg::PH_INSP),
        {1'b0, tick_reg} <= ({1'b0, limit_reg} + 14'd1))

endmodule

### sim/tb_breath_cycle_phase_timer.sv
`timescale 1ns / 1ps

module tb_breath_cycle_phase_timer;

    localparam int          TICK_MS   = 10;
    localparam logic [1:0]  OP_UNUSED = 2'd3;
    localparam int          TIME_MAX  = 8191;
    localparam int          TICKS_MAX = 8190;

    logic           aclk;
    logic           aresetn;
    logic           s_valid;
    logic           s_ready;
    bcpt_pkg::in_t  s_data;
    logic           m_valid;
    logic           m_ready;
    bcpt_pkg::out_t m_data;
    logic           cfg_we;
    logic           cfg_addr;
    logic [5:0]     cfg_wdata;

    // Timer model state and its copy of the registers
    logic [2:0]  tm_phase;
    logic [12:0] tm_ticks;
    logic [12:0] tm_limit;
    logic        tm_run;
    logic [5:0]  tm_rate;
    logic [2:0]  tm_ie;

    bcpt_pkg::out_t pending_results[$];
    int             mismatch_count;
    int             tx_idle_pct;
    int             rx_idle_pct;
    int             rx_hold_len;

    breath_cycle_phase_timer #(
        .TICK_MS(TICK_MS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Inspiration time in ms, saturated to 13 bits
    function automatic int unsigned insp_ms();
        int unsigned d;
        int unsigned t;
        d = int'(tm_rate) * (int'(tm_ie) + 1);
        if (d == 0) begin
            return TIME_MAX;
        end
        t = 60000 / d;
        return (t > TIME_MAX) ? TIME_MAX : t;
    endfunction

    function automatic int unsigned exp_ms();
        int unsigned t;
        t = insp_ms() * int'(tm_ie);
        return (t > TIME_MAX) ? TIME_MAX : t;
    endfunction

    function automatic logic [12:0] ticks_of(int unsigned ms);
        int unsigned q;
        q = ms / TICK_MS;
        return (q > TICKS_MAX) ? 13'(TICKS_MAX) : 13'(q);
    endfunction

    // Advance the timer model by one request and return the result it reports
    function automatic bcpt_pkg::out_t step_timer(bcpt_pkg::in_t req);
        bcpt_pkg::out_t res;
        if (req.op == bcpt_pkg::OP_TICK) begin
            case (tm_phase)
                bcpt_pkg::PH_HOME: begin
                    if (req.sensor_error) begin
                        tm_run = 1'b0;
                    end
                    tm_ticks = '0;
                    tm_phase = bcpt_pkg::PH_INIT_EXP;
                end
                bcpt_pkg::PH_INIT_EXP: begin
                    tm_limit = ticks_of(exp_ms());
                    tm_ticks = '0;
                    tm_phase = bcpt_pkg::PH_EXP;
                end
                bcpt_pkg::PH_INIT_INSP: begin
                    tm_limit = ticks_of(insp_ms());
                    tm_ticks = '0;
                    tm_phase = bcpt_pkg::PH_INSP;
                end
                bcpt_pkg::PH_EXP, bcpt_pkg::PH_INSP: begin
                    if (tm_ticks > tm_limit) begin
                        tm_phase = (tm_phase == bcpt_pkg::PH_EXP) ?
                                   bcpt_pkg::PH_INIT_INSP : bcpt_pkg::PH_INIT_EXP;
                        tm_ticks = '0;
                    end else begin
                        tm_ticks = tm_ticks + 13'd1;
                    end
                end
                default: begin
                end
            endcase
        end else if (req.op == bcpt_pkg::OP_START) begin
            tm_run = 1'b1;
        end else if (req.op == bcpt_pkg::OP_STOP) begin
            tm_run = 1'b0;
        end
        res.phase        = tm_phase;
        res.running      = tm_run;
        res.insp_time_ms = 13'(insp_ms());
        res.exp_time_ms  = 13'(exp_ms());
        res.phase_ticks  = tm_ticks;
        return res;
    endfunction

    // Offer one request, wait for the handshake, then queue its result
    task automatic send_request(logic [1:0] op, logic err);
        bcpt_pkg::in_t req;
        int            gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < tx_idle_pct) begin
            gap++;
        end
        req.op           = op;
        req.sensor_error = err;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = req;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        pending_results.push_back(step_timer(req));
    endtask

    // Drop valid and wait until every queued result has come back
    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_reg(logic addr, logic [5:0] value);
        drain_results();
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (addr == bcpt_pkg::REG_BREATH_RATE) begin
            tm_rate = value;
        end else begin
            tm_ie = value[2:0];
        end
    endtask

    // Unused opcode, start/stop and the sensor fault in the home phase
    task automatic test_flags_at_home();
        send_request(OP_UNUSED, 1'b0);
        send_request(OP_UNUSED, 1'b1);
        send_request(bcpt_pkg::OP_START, 1'b0);
        send_request(bcpt_pkg::OP_START, 1'b1);
        send_request(bcpt_pkg::OP_TICK, 1'b1);
        send_request(bcpt_pkg::OP_START, 1'b0);
        send_request(bcpt_pkg::OP_TICK, 1'b1);
        send_request(bcpt_pkg::OP_STOP, 1'b1);
        send_request(bcpt_pkg::OP_TICK, 1'b0);
        send_request(bcpt_pkg::OP_START, 1'b0);
        send_request(OP_UNUSED, 1'b0);
    endtask

    // Zero rate, large times, zero ratio and the register extremes
    task automatic test_config_extremes();
        write_reg(bcpt_pkg::REG_BREATH_RATE, 6'd0);
        send_request(bcpt_pkg::OP_TICK, 1'b0);
        send_request(bcpt_pkg::OP_STOP, 1'b0);
        write_reg(bcpt_pkg::REG_BREATH_RATE, 6'd1);
        write_reg(bcpt_pkg::REG_IE_RATIO, 6'd0);
        send_request(bcpt_pkg::OP_TICK, 1'b1);
        send_request(OP_UNUSED, 1'b1);
        write_reg(bcpt_pkg::REG_BREATH_RATE, 6'd63);
        write_reg(bcpt_pkg::REG_IE_RATIO, 6'd7);
        send_request(bcpt_pkg::OP_TICK, 1'b0);
        send_request(bcpt_pkg::OP_START, 1'b0);
        write_reg(bcpt_pkg::REG_BREATH_RATE, 6'd6);
        write_reg(bcpt_pkg::REG_IE_RATIO, 6'd4);
        send_request(bcpt_pkg::OP_TICK, 1'b0);
        write_reg(bcpt_pkg::REG_BREATH_RATE, 6'd60);
        send_request(bcpt_pkg::OP_TICK, 1'b0);
        send_request(bcpt_pkg::OP_TICK, 1'b1);
    endtask

    // Run the phase machine through whole breaths under changing settings
    task automatic test_random_breaths(int n_items);
        int       sent;
        int       seg;
        int       r;
        logic [1:0] op;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) < 7) begin
                write_reg(bcpt_pkg::REG_BREATH_RATE, 6'($urandom_range(50, 63)));
                write_reg(bcpt_pkg::REG_IE_RATIO, 6'($urandom_range(4, 7)));
            end else begin
                write_reg(bcpt_pkg::REG_BREATH_RATE, 6'($urandom_range(0, 63)));
                write_reg(bcpt_pkg::REG_IE_RATIO, 6'($urandom_range(0, 7)));
            end
            seg = $urandom_range(30, 60);
            repeat (seg) begin
                r = $urandom_range(99);
                if (r < 82) begin
                    op = bcpt_pkg::OP_TICK;
                end else if (r < 88) begin
                    op = bcpt_pkg::OP_START;
                end else if (r < 94) begin
                    op = bcpt_pkg::OP_STOP;
                end else begin
                    op = OP_UNUSED;
                end
                send_request(op, ($urandom_range(7) == 0));
            end
            sent += seg;
        end
    endtask

    // Hold off the result side while requests keep coming, so the input stalls
    task automatic test_backpressure();
        int saved_idle;
        saved_idle  = tx_idle_pct;
        tx_idle_pct = 0;
        rx_hold_len = 400;
        repeat (10) send_request(bcpt_pkg::OP_TICK, 1'($urandom_range(1)));
        tx_idle_pct = saved_idle;
    endtask

    // Drive the result-side ready, with an optional long hold-off
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_len > 0) begin
                m_ready     = 1'b0;
                rx_hold_len = rx_hold_len - 1;
            end else begin
                m_ready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each result with the oldest queued one
    always @(posedge aclk) begin
        bcpt_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none pending, got %h", $time, m_data);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("phase", want.phase, m_data.phase);
                check_field("running", want.running, m_data.running);
                check_field("insp_time_ms", want.insp_time_ms, m_data.insp_time_ms);
                check_field("exp_time_ms", want.exp_time_ms, m_data.exp_time_ms);
                check_field("phase_ticks", want.phase_ticks, m_data.phase_ticks);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb_breath_cycle_phase_timer: done, errors");
        $finish;
    end

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        cfg_we         = 1'b0;
        cfg_addr       = bcpt_pkg::REG_BREATH_RATE;
        cfg_wdata      = '0;
        mismatch_count = 0;
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        rx_hold_len    = 0;
        tm_phase       = bcpt_pkg::PH_HOME;
        tm_ticks       = '0;
        tm_limit       = '0;
        tm_run         = 1'b0;
        tm_rate        = bcpt_pkg::RATE_RESET;
        tm_ie          = bcpt_pkg::IE_RESET;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_flags_at_home();
        test_config_extremes();
        tx_idle_pct = 35;
        rx_idle_pct = 66;
        test_random_breaths(120);
        tx_idle_pct = 66;
        rx_idle_pct = 35;
        test_backpressure();
        test_random_breaths(120);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_breaths(120);

        drain_results();
        repeat (60) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_breath_cycle_phase_timer: done, clean");
        end else begin
            $display("tb_breath_cycle_phase_timer: done, errors");
        end
        $finish;
    end

endmodule
